// ----- design/rwd_pkg.sv -----
// Shared types and constants for the RIFF/WAVE duration parser.
// No dependencies; every other design file imports this package.
package rwd_pkg;

  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH           = 2;
  localparam int DURATION_W            = 48;

  // Chunk tags as they appear after little-endian byte assembly
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN  = 32'd16;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_BAD_FMT    = 2'd2;
  localparam logic [1:0] ST_NO_DATA    = 2'd3;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [DURATION_W-1:0] duration_q16;
    logic [31:0]           data_bytes;
    logic [31:0]           bytes_per_second;
  } out_item_t;

  // Work handed from the parser to the divider
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_bytes;
    logic [31:0] rate;
    logic        with_duration;
  } job_t;

endpackage

// ----- design/rwd_front.sv -----
// Byte-level RIFF/WAVE chunk parser: classifies the stream and issues one job per file.
// Depends on rwd_pkg.
module rwd_front
  import rwd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_item_t byte_item,
  output logic     job_valid,
  output job_t     job
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  count, count_next;
  logic [31:0] tag, tag_next;
  logic [31:0] len, len_next;
  logic [32:0] skip, skip_next;
  logic [31:0] rate, rate_next;

  logic        emit;
  job_t        job_next;

  always_comb begin
    logic [7:0] b;
    b          = byte_item.file_byte;
    phase_next = phase;
    count_next = count;
    tag_next   = tag;
    len_next   = len;
    skip_next  = skip;
    rate_next  = rate;
    emit       = 1'b0;
    job_next   = '0;

    case (phase)
      PH_HEADER: begin
        tag_next   = {b, tag[31:8]};
        count_next = count + 5'd1;
        if (count_next == 5'd4 && tag_next != TAG_RIFF) begin
          len_next = 32'd1;
        end
        if (count_next >= 5'd12) begin
          if (tag_next != TAG_WAVE || len_next[0]) begin
            emit            = 1'b1;
            job_next.status = ST_BAD_HEADER;
            phase_next      = PH_DONE;
          end else begin
            phase_next = PH_CHUNK;
          end
          count_next = '0;
          tag_next   = '0;
          len_next   = '0;
        end
      end
      PH_CHUNK: begin
        if (count < 5'd4) begin
          tag_next = {b, tag[31:8]};
        end else begin
          len_next = {b, len[31:8]};
        end
        count_next = count + 5'd1;
        if (count_next >= 5'd8) begin
          count_next = '0;
          if (tag_next == TAG_FMT) begin
            if (len_next < FMT_MIN) begin
              emit            = 1'b1;
              job_next.status = ST_BAD_FMT;
              phase_next      = PH_DONE;
            end else begin
              tag_next   = '0;
              phase_next = PH_FMT;
            end
          end else if (tag_next == TAG_DATA) begin
            emit                   = 1'b1;
            job_next.data_bytes    = len_next;
            job_next.with_duration = (rate != '0);
            job_next.status        = (rate != '0) ? ST_OK : ST_NO_DATA;
            phase_next             = PH_DONE;
          end else begin
            skip_next  = {1'b0, len_next} + 33'(len_next[0]);
            phase_next = (skip_next != '0) ? PH_SKIP : PH_CHUNK;
          end
        end
      end
      PH_FMT: begin
        if (count >= 5'd8 && count < 5'd12) begin
          tag_next = {b, tag[31:8]};
        end
        count_next = count + 5'd1;
        if (count_next >= 5'd16) begin
          count_next = '0;
          rate_next  = tag_next;
          tag_next   = '0;
          skip_next  = {1'b0, len - FMT_MIN} + 33'(len[0]);
          phase_next = (skip_next != '0) ? PH_SKIP : PH_CHUNK;
        end
      end
      PH_SKIP: begin
        if (skip != '0) begin
          skip_next = skip - 33'd1;
        end
        if (skip_next == '0) begin
          count_next = '0;
          tag_next   = '0;
          len_next   = '0;
          phase_next = PH_CHUNK;
        end
      end
      default: begin
      end
    endcase

    job_next.rate = rate_next;

    // End of stream: report where parsing stopped, then start over
    if (byte_item.last) begin
      if (!emit) begin
        case (phase_next)
          PH_HEADER: begin
            emit            = 1'b1;
            job_next.status = ST_BAD_HEADER;
          end
          PH_FMT: begin
            emit            = 1'b1;
            job_next.status = ST_BAD_FMT;
          end
          PH_CHUNK, PH_SKIP: begin
            emit            = 1'b1;
            job_next.status = ST_NO_DATA;
          end
          default: begin
          end
        endcase
      end
      phase_next = PH_HEADER;
      count_next = '0;
      tag_next   = '0;
      len_next   = '0;
      skip_next  = '0;
      rate_next  = '0;
    end
  end

  assign job_valid = accept && emit;
  assign job       = job_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      count <= '0;
      tag   <= '0;
      len   <= '0;
      skip  <= '0;
      rate  <= '0;
    end else if (accept) begin
      phase <= phase_next;
      count <= count_next;
      tag   <= tag_next;
      len   <= len_next;
      skip  <= skip_next;
      rate  <= rate_next;
    end
  end

endmodule

// ----- design/rwd_queue.sv -----
// Short job queue between the parser and the divider.
// Depends on rwd_pkg.
module rwd_queue
  import rwd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic q_full,
  output logic q_empty,
  input  logic rd_en,
  output job_t rd_job
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_wr, do_rd;

  assign q_full  = (fill == CNT_W'(QUEUE_DEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- design/rwd_divider.sv -----
// Back end: restoring divider for the duration and the result register.
// Depends on rwd_pkg.
module rwd_divider
  import rwd_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      job_ready,
  input  job_t      job,
  output logic      job_take,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  localparam int QW    = 32 + FRACTION_BITS;
  localparam int CNT_W = $clog2(QW + 1);

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t           state;
  logic             out_valid;
  logic [QW-1:0]    quot;
  logic [32:0]      rem;
  logic [CNT_W-1:0] steps;
  logic [1:0]       hold_status;
  logic [31:0]      hold_bytes;
  logic [31:0]      hold_rate;

  logic [32:0]   rem_shift;
  logic          q_bit;
  logic [32:0]   rem_step;
  logic [QW-1:0] quot_step;
  logic [63:0]   quot_wide;
  logic [DURATION_W-1:0] dur_sat;

  // One quotient bit per cycle, MSB first; dividend bits shift out of quot
  assign rem_shift = {rem[31:0], quot[QW-1]};
  assign q_bit     = (rem_shift >= {1'b0, hold_rate});
  assign rem_step  = q_bit ? rem_shift - {1'b0, hold_rate} : rem_shift;
  assign quot_step = {quot[QW-2:0], q_bit};
  assign quot_wide = 64'(quot_step);
  assign dur_sat   = (|quot_wide[63:DURATION_W]) ? '1 : quot_wide[DURATION_W-1:0];

  assign job_take = (state == S_IDLE) && !out_valid && job_ready;
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (job_take) begin
            hold_status <= job.status;
            hold_bytes  <= job.data_bytes;
            hold_rate   <= job.rate;
            if (job.with_duration) begin
              quot  <= QW'({job.data_bytes, {FRACTION_BITS{1'b0}}});
              rem   <= '0;
              steps <= CNT_W'(QW);
              state <= S_DIV;
            end else begin
              result.status           <= job.status;
              result.duration_q16     <= '0;
              result.data_bytes       <= job.data_bytes;
              result.bytes_per_second <= job.rate;
              out_valid               <= 1'b1;
            end
          end
        end
        S_DIV: begin
          quot  <= quot_step;
          rem   <= rem_step;
          steps <= steps - CNT_W'(1);
          if (steps == CNT_W'(1)) begin
            result.status           <= hold_status;
            result.duration_q16     <= dur_sat;
            result.data_bytes       <= hold_bytes;
            result.bytes_per_second <= hold_rate;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/riff_wave_duration_parser.sv -----
// Top level of the RIFF/WAVE duration parser.
// Depends on rwd_pkg, rwd_front, rwd_queue and rwd_divider.

// Feed a WAV file one byte per cycle on the push side; each file yields exactly one
// result (status, duration in Q32.FRACTION_BITS seconds, data size, byte rate), issued
// at the data chunk header, at the first header error, or at the byte marked last.
// The parser takes one byte per cycle while the job queue has room. An ok result
// goes through the one-bit-per-cycle restoring divider; an error result passes from
// the job queue to the result register without division. Bytes after a result are ignored
// until the last byte, which returns the parser to its reset state.
module riff_wave_duration_parser
  import rwd_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  byte_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  logic accept;
  logic job_valid;
  job_t job_in;
  job_t job_out;
  logic q_full, q_empty;
  logic job_take;

  assign full   = q_full;
  assign accept = push && !full;

  rwd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_item (byte_item),
    .job_valid (job_valid),
    .job       (job_in)
  );

  rwd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_valid),
    .wr_job  (job_in),
    .q_full  (q_full),
    .q_empty (q_empty),
    .rd_en   (job_take),
    .rd_job  (job_out)
  );

  rwd_divider #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .job_ready (!q_empty),
    .job       (job_out),
    .job_take  (job_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ----- design/rwd_checker.sv -----
// Port-level checks for the RIFF/WAVE duration parser, bound to the top level.
// Depends on rwd_pkg and riff_wave_duration_parser.
module rwd_checker
  import rwd_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      empty,
  input logic      pop,
  input out_item_t result
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

  a_error_no_duration: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != ST_OK) |-> (result.duration_q16 == '0))
    else $error("error result carries a duration");

  a_ok_has_rate: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_OK) |-> (result.bytes_per_second != '0))
    else $error("ok result with zero byte rate");

  a_early_error_no_size: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.status == ST_BAD_HEADER || result.status == ST_BAD_FMT))
      |-> (result.data_bytes == '0))
    else $error("header or fmt error reports a data size");

endmodule

bind riff_wave_duration_parser rwd_checker u_rwd_checker (.*);

// ----- bench/riff_wave_duration_parser_test.sv -----
// Self-checking bench for riff_wave_duration_parser: byte stream in, one result per file out.
// Depends on rwd_pkg and the design files; the expected results come from an in-bench parser.
`timescale 1ns / 100ps

module riff_wave_duration_parser_test;
  import rwd_pkg::*;

  localparam int FRAC        = FRACTION_BITS_DEFAULT;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_BYTES = 470;
  localparam int PHASE_FILES = 12;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_FMT    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_DONE   = 3'd4
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last;
    logic       typed_in;
    out_item_t  want;
  } dir_row_t;

  localparam out_item_t NO_RESULT = '0;

  // Short files: one-byte file, a data chunk with no fmt ahead of it (largest size),
  // a byte ignored after the result, then another one-byte file.
  localparam dir_row_t DIRECTED_ROWS [23] = '{
    '{8'h52, 1'b1, 1'b1, '{ST_BAD_HEADER, 48'd0, 32'd0, 32'd0}},
    '{8'h52, 1'b0, 1'b0, NO_RESULT},
    '{8'h49, 1'b0, 1'b0, NO_RESULT},
    '{8'h46, 1'b0, 1'b0, NO_RESULT},
    '{8'h46, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h57, 1'b0, 1'b0, NO_RESULT},
    '{8'h41, 1'b0, 1'b0, NO_RESULT},
    '{8'h56, 1'b0, 1'b0, NO_RESULT},
    '{8'h45, 1'b0, 1'b0, NO_RESULT},
    '{8'h64, 1'b0, 1'b0, NO_RESULT},
    '{8'h61, 1'b0, 1'b0, NO_RESULT},
    '{8'h74, 1'b0, 1'b0, NO_RESULT},
    '{8'h61, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b1, '{ST_NO_DATA, 48'd0, 32'hFFFF_FFFF, 32'd0}},
    '{8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b1, '{ST_BAD_HEADER, 48'd0, 32'd0, 32'd0}}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_item_t  byte_item = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_item_t result;

  riff_wave_duration_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .byte_item (byte_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Parser state mirrored in the bench
  parse_phase_e p_phase;
  logic [4:0]   p_count;
  logic [31:0]  p_tag;
  logic [31:0]  p_len;
  logic [32:0]  p_skip;
  logic [31:0]  p_rate;

  out_item_t  pending_results[$];
  logic [7:0] file_bytes[$];
  int         send_idle = 0;
  int         recv_idle = 0;
  int         phase_no = -1;
  int         errors = 0;

  task automatic clear_parser();
    p_phase = PH_HEADER;
    p_count = '0;
    p_tag   = '0;
    p_len   = '0;
    p_skip  = '0;
    p_rate  = '0;
  endtask

  function automatic out_item_t make_result(logic [1:0] st, logic [31:0] nbytes, logic with_dur);
    logic [63:0] q;
    out_item_t   r;
    q = '0;
    if (with_dur && p_rate != 0) begin
      q = ({32'd0, nbytes} << FRAC) / {32'd0, p_rate};
      if (q > 64'h0000_FFFF_FFFF_FFFF) q = 64'h0000_FFFF_FFFF_FFFF;
    end
    r.status           = st;
    r.duration_q16     = q[DURATION_W-1:0];
    r.data_bytes       = nbytes;
    r.bytes_per_second = p_rate;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic is_last,
                            output logic got, output out_item_t res);
    got = 1'b0;
    res = '0;
    case (p_phase)
      PH_HEADER: begin
        p_tag   = {b, p_tag[31:8]};
        p_count = p_count + 5'd1;
        if (p_count == 4 && p_tag != TAG_RIFF) p_len = 32'd1;
        if (p_count >= 12) begin
          if (p_tag != TAG_WAVE || p_len[0]) begin
            res = make_result(ST_BAD_HEADER, 32'd0, 1'b0);
            got = 1'b1;
            p_phase = PH_DONE;
          end else begin
            p_phase = PH_CHUNK;
          end
          p_count = '0;
          p_tag   = '0;
          p_len   = '0;
        end
      end
      PH_CHUNK: begin
        if (p_count < 4) p_tag = {b, p_tag[31:8]};
        else p_len = {b, p_len[31:8]};
        p_count = p_count + 5'd1;
        if (p_count >= 8) begin
          p_count = '0;
          if (p_tag == TAG_FMT) begin
            if (p_len < FMT_MIN) begin
              res = make_result(ST_BAD_FMT, 32'd0, 1'b0);
              got = 1'b1;
              p_phase = PH_DONE;
            end else begin
              p_tag   = '0;
              p_phase = PH_FMT;
            end
          end else if (p_tag == TAG_DATA) begin
            if (p_rate == 0) res = make_result(ST_NO_DATA, p_len, 1'b0);
            else res = make_result(ST_OK, p_len, 1'b1);
            got = 1'b1;
            p_phase = PH_DONE;
          end else begin
            // odd chunks carry one pad byte
            p_skip  = {1'b0, p_len} + {32'd0, p_len[0]};
            p_phase = (p_skip != 0) ? PH_SKIP : PH_CHUNK;
          end
        end
      end
      PH_FMT: begin
        if (p_count >= 8 && p_count < 12) p_tag = {b, p_tag[31:8]};
        p_count = p_count + 5'd1;
        if (p_count >= FMT_MIN) begin
          p_count = '0;
          p_rate  = p_tag;
          p_tag   = '0;
          p_skip  = {1'b0, p_len - FMT_MIN} + {32'd0, p_len[0]};
          p_phase = (p_skip != 0) ? PH_SKIP : PH_CHUNK;
        end
      end
      PH_SKIP: begin
        if (p_skip != 0) p_skip = p_skip - 33'd1;
        if (p_skip == 0) begin
          p_count = '0;
          p_tag   = '0;
          p_len   = '0;
          p_phase = PH_CHUNK;
        end
      end
      default: ;
    endcase

    if (is_last) begin
      if (!got) begin
        if (p_phase == PH_HEADER) begin
          res = make_result(ST_BAD_HEADER, 32'd0, 1'b0);
          got = 1'b1;
        end else if (p_phase == PH_FMT) begin
          res = make_result(ST_BAD_FMT, 32'd0, 1'b0);
          got = 1'b1;
        end else if (p_phase == PH_CHUNK || p_phase == PH_SKIP) begin
          res = make_result(ST_NO_DATA, 32'd0, 1'b0);
          got = 1'b1;
        end
      end
      clear_parser();
    end
  endtask

  // Offer one byte; returns at the edge where the transfer happens.
  task automatic offer_byte(input logic [7:0] b, input logic l, input logic typed_in,
                            input out_item_t want);
    logic      got;
    out_item_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push      <= 1'b1;
    byte_item <= '{file_byte: b, last: l};
    do @(posedge clk); while (full);
    parse_byte(b, l, got, res);
    if (typed_in) pending_results.push_back(want);
    else if (got) pending_results.push_back(res);
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
  endtask

  function automatic logic [31:0] pick_rate();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd1;
    if (r == 2) return 32'hFFFF_FFFF;
    if (r < 7) return $urandom_range(8000, 192000);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_data_size();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 5) return $urandom;
    return $urandom_range(0, 1000000);
  endfunction

  // Mostly well-formed files with random content, some broken or cut short, a few noise.
  task automatic build_file();
    int          idx;
    int          nchunks;
    int          sel;
    int          cut;
    int          n;
    logic [31:0] len;
    logic [31:0] tag;
    logic [31:0] rate;
    file_bytes.delete();
    cut = 0;
    if ($urandom_range(99) < 8) begin
      n = $urandom_range(1, 20);
      repeat (n) file_bytes.push_back(8'($urandom_range(255)));
      return;
    end
    push_word(TAG_RIFF);
    push_word($urandom);
    push_word(TAG_WAVE);
    if ($urandom_range(99) < 8) begin
      idx = $urandom_range(0, 7);
      if (idx >= 4) idx += 4;
      file_bytes[idx] = file_bytes[idx] ^ (8'h01 << $urandom_range(7));
    end
    nchunks = $urandom_range(0, 3);
    for (int c = 0; c < nchunks && cut == 0; c++) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        len = ($urandom_range(99) < 8) ? $urandom_range(0, 15) : $urandom_range(16, 21);
        rate = pick_rate();
        push_word(TAG_FMT);
        push_word(len);
        for (int i = 0; i < len; i++) begin
          if (i >= 8 && i < 12) file_bytes.push_back(rate[8*(i-8) +: 8]);
          else file_bytes.push_back(8'($urandom_range(255)));
        end
        if (len[0]) file_bytes.push_back(8'($urandom_range(255)));
      end else if (sel < 88) begin
        tag = $urandom;
        if ($urandom_range(99) < 30)
          tag = ($urandom_range(1) ? TAG_FMT : TAG_DATA) ^ (32'd1 << $urandom_range(31));
        len = $urandom_range(0, 9);
        push_word(tag);
        push_word(len);
        for (int i = 0; i < len + len[0]; i++) file_bytes.push_back(8'($urandom_range(255)));
      end else begin
        // huge chunk, stream ends while it is being skipped
        push_word($urandom);
        push_word($urandom | 32'h0000_0100);
        n = $urandom_range(0, 5);
        repeat (n) file_bytes.push_back(8'($urandom_range(255)));
        cut = 1;
      end
    end
    if (cut == 0) begin
      if ($urandom_range(99) < 85) begin
        push_word(TAG_DATA);
        push_word(pick_data_size());
        n = $urandom_range(0, 3);
      end else begin
        n = $urandom_range(0, 5);
      end
      repeat (n) file_bytes.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > n) void'(file_bytes.pop_back());
    end
  endtask

  // Receiver side: random pop, plus one long hold-off in the last phase
  initial begin : result_side
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_no == 2 && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: status %0d duration %0h data %0h rate %0h", $time,
                 result.status, result.duration_q16, result.data_bytes,
                 result.bytes_per_second);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (result.status !== e.status) begin
          $display("%0t status: expected %0d actual %0d", $time, e.status, result.status);
          errors++;
        end
        if (result.duration_q16 !== e.duration_q16) begin
          $display("%0t duration_q16: expected %0h actual %0h", $time, e.duration_q16,
                   result.duration_q16);
          errors++;
        end
        if (result.data_bytes !== e.data_bytes) begin
          $display("%0t data_bytes: expected %0h actual %0h", $time, e.data_bytes,
                   result.data_bytes);
          errors++;
        end
        if (result.bytes_per_second !== e.bytes_per_second) begin
          $display("%0t bytes_per_second: expected %0h actual %0h", $time,
                   e.bytes_per_second, result.bytes_per_second);
          errors++;
        end
      end
    end
  end

  initial begin : byte_side
    int phase_bytes;
    int phase_files;
    clear_parser();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 33;
    recv_idle = 70;
    foreach (DIRECTED_ROWS[i])
      offer_byte(DIRECTED_ROWS[i].file_byte, DIRECTED_ROWS[i].last,
                 DIRECTED_ROWS[i].typed_in, DIRECTED_ROWS[i].want);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle = 33; recv_idle = 70; end
        1: begin send_idle = 70; recv_idle = 33; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      phase_no = ph;
      phase_bytes = 0;
      phase_files = 0;
      while (phase_bytes < PHASE_BYTES || phase_files < PHASE_FILES) begin
        build_file();
        foreach (file_bytes[i])
          offer_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, NO_RESULT);
        phase_bytes += file_bytes.size();
        phase_files++;
      end
    end
    @(negedge clk);
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    // let any stray transfer show up
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
